// File: rtl/core/csl_pkg.sv
package csl_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_STR_ESC, M_CHAR_BODY,
        M_CHAR_ESC, M_CHAR_CLOSE, M_OP1, M_OP2, M_COMMENT, M_DONE
    } t_mode;

    localparam logic [6:0] K_EOF      = 7'd0;
    localparam logic [6:0] K_NUMBER   = 7'd1;
    localparam logic [6:0] K_IDENT    = 7'd2;
    localparam logic [6:0] K_STRING   = 7'd3;
    localparam logic [6:0] K_CHARLIT  = 7'd4;
    localparam logic [6:0] K_KW_BASE  = 7'd5;
    localparam logic [6:0] K_PAREN_O  = 7'd23;
    localparam logic [6:0] K_PAREN_C  = 7'd24;
    localparam logic [6:0] K_SEMI     = 7'd25;
    localparam logic [6:0] K_BRACE_O  = 7'd26;
    localparam logic [6:0] K_BRACE_C  = 7'd27;
    localparam logic [6:0] K_COMMA    = 7'd28;
    localparam logic [6:0] K_BRACK_O  = 7'd29;
    localparam logic [6:0] K_BRACK_C  = 7'd30;
    localparam logic [6:0] K_TILDE    = 7'd31;
    localparam logic [6:0] K_COLON    = 7'd32;
    localparam logic [6:0] K_VARARG   = 7'd33;
    localparam logic [6:0] K_MEMBER   = 7'd34;
    localparam logic [6:0] K_ADDEQ    = 7'd35;
    localparam logic [6:0] K_INC      = 7'd36;
    localparam logic [6:0] K_ADD      = 7'd37;
    localparam logic [6:0] K_SUBEQ    = 7'd38;
    localparam logic [6:0] K_DEC      = 7'd39;
    localparam logic [6:0] K_ARROW    = 7'd40;
    localparam logic [6:0] K_SUB      = 7'd41;
    localparam logic [6:0] K_MULEQ    = 7'd42;
    localparam logic [6:0] K_MUL      = 7'd43;
    localparam logic [6:0] K_DIVEQ    = 7'd44;
    localparam logic [6:0] K_DIV      = 7'd45;
    localparam logic [6:0] K_REMEQ    = 7'd46;
    localparam logic [6:0] K_REM      = 7'd47;
    localparam logic [6:0] K_ANDEQ    = 7'd48;
    localparam logic [6:0] K_LOGAND   = 7'd49;
    localparam logic [6:0] K_AND      = 7'd50;
    localparam logic [6:0] K_OREQ     = 7'd51;
    localparam logic [6:0] K_LOGOR    = 7'd52;
    localparam logic [6:0] K_OR       = 7'd53;
    localparam logic [6:0] K_XOREQ    = 7'd54;
    localparam logic [6:0] K_XOR      = 7'd55;
    localparam logic [6:0] K_LE       = 7'd56;
    localparam logic [6:0] K_SHLEQ    = 7'd57;
    localparam logic [6:0] K_SHL      = 7'd58;
    localparam logic [6:0] K_LT       = 7'd59;
    localparam logic [6:0] K_GE       = 7'd60;
    localparam logic [6:0] K_SHREQ    = 7'd61;
    localparam logic [6:0] K_SHR      = 7'd62;
    localparam logic [6:0] K_GT       = 7'd63;
    localparam logic [6:0] K_EQ       = 7'd64;
    localparam logic [6:0] K_ASSIGN   = 7'd65;
    localparam logic [6:0] K_NE       = 7'd66;
    localparam logic [6:0] K_BANG     = 7'd67;
    localparam logic [6:0] K_TEXT     = 7'd68;
    localparam logic [6:0] K_ERROR    = 7'd69;

    localparam logic [2:0] E_NONE       = 3'd0;
    localparam logic [2:0] E_UNEXPECTED = 3'd1;
    localparam logic [2:0] E_BAD_ESC    = 3'd2;
    localparam logic [2:0] E_OPEN_STR   = 3'd3;
    localparam logic [2:0] E_OPEN_CHAR  = 3'd4;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    // Result without position; position is chosen from a small code.
    typedef enum logic [1:0] {
        P_START, P_START_NEXT, P_CUR
    } t_pos_sel;

    typedef struct packed {
        logic [6:0]  kind;
        t_pos_sel    pos;
        logic [30:0] num;
        logic [7:0]  chr;
        logic [2:0]  err;
    } t_res;

    typedef struct packed {
        logic [1:0] count;
        t_res       r0;
        t_res       r1;
        t_res       r2;
    } t_burst;

    localparam logic [63:0] KW_TEXT [18] = '{
        64'h0000_6e72_7574_6572, 64'h0000_0000_0000_6669,
        64'h0000_0000_6573_6c65, 64'h0000_0065_6c69_6877,
        64'h0000_0000_0072_6f66, 64'h0000_0000_0074_6e69,
        64'h0000_666f_657a_6973, 64'h0000_0000_7261_6863,
        64'h0000_006b_6165_7262, 64'h6575_6e69_746e_6f63,
        64'h0000_6863_7469_7773, 64'h0000_0000_6573_6163,
        64'h0074_6c75_6166_6564, 64'h0000_7463_7572_7473,
        64'h0066_6564_6570_7974, 64'h0000_006e_6f69_6e75,
        64'h0000_0000_6d75_6e65, 64'h0000_0000_6469_6f76
    };
    localparam logic [3:0] KW_LEN [18] = '{
        4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd3, 4'd6, 4'd4, 4'd5,
        4'd8, 4'd6, 4'd4, 4'd7, 4'd6, 4'd7, 4'd5, 4'd4, 4'd4
    };

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    // Returns {valid, value}.
    function automatic logic [8:0] decode_escape(input logic [7:0] b);
        case (b)
            8'h6e:   return {1'b1, 8'h0a};
            8'h5c:   return {1'b1, 8'h5c};
            8'h27:   return {1'b1, 8'h27};
            8'h22:   return {1'b1, 8'h22};
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic [7:0] single_kind(input logic [7:0] b);
        case (b)
            8'h28:   return {1'b1, K_PAREN_O};
            8'h29:   return {1'b1, K_PAREN_C};
            8'h3b:   return {1'b1, K_SEMI};
            8'h7b:   return {1'b1, K_BRACE_O};
            8'h7d:   return {1'b1, K_BRACE_C};
            8'h2c:   return {1'b1, K_COMMA};
            8'h5b:   return {1'b1, K_BRACK_O};
            8'h5d:   return {1'b1, K_BRACK_C};
            8'h7e:   return {1'b1, K_TILDE};
            8'h3a:   return {1'b1, K_COLON};
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] lead_kind(input logic [7:0] b);
        case (b)
            8'h2e:   return {1'b1, K_MEMBER};
            8'h2b:   return {1'b1, K_ADD};
            8'h2d:   return {1'b1, K_SUB};
            8'h2a:   return {1'b1, K_MUL};
            8'h2f:   return {1'b1, K_DIV};
            8'h25:   return {1'b1, K_REM};
            8'h26:   return {1'b1, K_AND};
            8'h7c:   return {1'b1, K_OR};
            8'h5e:   return {1'b1, K_XOR};
            8'h3c:   return {1'b1, K_LT};
            8'h3e:   return {1'b1, K_GT};
            8'h3d:   return {1'b1, K_ASSIGN};
            8'h21:   return {1'b1, K_BANG};
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] pair_kind(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] k;
        k = 8'd0;
        if (b == 8'h3d) begin
            case (c)
                8'h2b:   k = {1'b1, K_ADDEQ};
                8'h2d:   k = {1'b1, K_SUBEQ};
                8'h2a:   k = {1'b1, K_MULEQ};
                8'h2f:   k = {1'b1, K_DIVEQ};
                8'h25:   k = {1'b1, K_REMEQ};
                8'h26:   k = {1'b1, K_ANDEQ};
                8'h7c:   k = {1'b1, K_OREQ};
                8'h5e:   k = {1'b1, K_XOREQ};
                8'h3c:   k = {1'b1, K_LE};
                8'h3e:   k = {1'b1, K_GE};
                8'h3d:   k = {1'b1, K_EQ};
                8'h21:   k = {1'b1, K_NE};
                default: k = 8'd0;
            endcase
        end else if (c == 8'h2b && b == 8'h2b) begin
            k = {1'b1, K_INC};
        end else if (c == 8'h2d && b == 8'h2d) begin
            k = {1'b1, K_DEC};
        end else if (c == 8'h2d && b == 8'h3e) begin
            k = {1'b1, K_ARROW};
        end else if (c == 8'h26 && b == 8'h26) begin
            k = {1'b1, K_LOGAND};
        end else if (c == 8'h7c && b == 8'h7c) begin
            k = {1'b1, K_LOGOR};
        end
        return k;
    endfunction

    function automatic t_res mk(input logic [6:0] kind, input t_pos_sel pos,
                                input logic [30:0] num, input logic [7:0] chr,
                                input logic [2:0] err);
        t_res r;
        r.kind = kind;
        r.pos  = pos;
        r.num  = num;
        r.chr  = chr;
        r.err  = err;
        return r;
    endfunction

endpackage

// File: rtl/core/csl_front.sv
// Front part: holds lexing state and turns each byte into a burst of up to
// three position-less results, plus the positions they refer to.
module csl_front #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic [7:0]             i_byte,
    input  logic                   i_eoi,
    output csl_pkg::t_burst        o_burst,
    output logic [LINE_BITS-1:0]   o_start_line,
    output logic [COLUMN_BITS-1:0] o_start_col,
    output logic [LINE_BITS-1:0]   o_cur_line,
    output logic [COLUMN_BITS-1:0] o_cur_col
);

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

    csl_pkg::t_mode          r_mode, n_mode;
    logic [7:0]              r_pend0, n_pend0, r_pend1, n_pend1;
    logic [30:0]             r_num, n_num;
    logic [63:0]             r_kwp, n_kwp;
    logic [3:0]              r_ilen, n_ilen;
    logic [LINE_BITS-1:0]    r_line, n_line, r_sline, n_sline;
    logic [COLUMN_BITS-1:0]  r_col, n_col, r_scol, n_scol;
    logic                    r_halt, n_halt;

    csl_pkg::t_res           res [3];
    logic [1:0]              cnt;

    logic [6:0]  ident_kind;
    logic [34:0] mul10;
    logic [35:0] num_sum;
    logic [8:0]  esc;
    logic [7:0]  pk, sk, lk;

    always_comb begin
        ident_kind = csl_pkg::K_IDENT;
        for (int i = 17; i >= 0; i--) begin
            if (r_ilen == csl_pkg::KW_LEN[i] && r_kwp == csl_pkg::KW_TEXT[i]) begin
                ident_kind = csl_pkg::K_KW_BASE + 7'(i);
            end
        end
    end

    assign mul10   = {1'b0, r_num, 3'b000} + {3'b000, r_num, 1'b0};
    assign num_sum = {1'b0, mul10} + {28'd0, i_byte - 8'h30};
    assign esc     = csl_pkg::decode_escape(i_byte);
    assign pk      = csl_pkg::pair_kind(r_pend0, i_byte);
    assign sk      = csl_pkg::single_kind(i_byte);
    assign lk      = csl_pkg::lead_kind(r_pend0);

    always_comb begin
        csl_pkg::t_res nr;
        logic          disp;
        logic [7:0]    dk;
        nr     = csl_pkg::mk(csl_pkg::K_EOF, csl_pkg::P_START, '0, '0, csl_pkg::E_NONE);
        res[0] = nr;
        res[1] = nr;
        res[2] = nr;
        cnt    = 2'd0;
        disp   = 1'b0;
        dk     = csl_pkg::lead_kind(i_byte);
        n_mode = r_mode;
        n_pend0 = r_pend0;
        n_pend1 = r_pend1;
        n_num  = r_num;
        n_kwp  = r_kwp;
        n_ilen = r_ilen;
        n_line = r_line;
        n_col  = r_col;
        n_sline = r_sline;
        n_scol = r_scol;
        n_halt = r_halt;

        if (!r_halt) begin
            if (r_mode == csl_pkg::M_DONE) begin
                res[0] = nr;
                res[0].pos = csl_pkg::P_CUR;
                cnt = 2'd1;
            end else if (i_eoi) begin
                case (r_mode)
                    csl_pkg::M_IDENT: begin
                        res[0].kind = ident_kind;
                        cnt = 2'd1;
                    end
                    csl_pkg::M_NUMBER: begin
                        res[0].kind = csl_pkg::K_NUMBER;
                        res[0].num = r_num;
                        cnt = 2'd1;
                    end
                    csl_pkg::M_STRING: begin
                        res[0] = csl_pkg::mk(csl_pkg::K_ERROR, csl_pkg::P_START, '0, '0,
                                             csl_pkg::E_OPEN_STR);
                        n_halt = 1'b1;
                    end
                    csl_pkg::M_STR_ESC, csl_pkg::M_CHAR_ESC: begin
                        res[0] = csl_pkg::mk(csl_pkg::K_ERROR, csl_pkg::P_CUR, '0, '0,
                                             csl_pkg::E_BAD_ESC);
                        n_halt = 1'b1;
                    end
                    csl_pkg::M_CHAR_BODY, csl_pkg::M_CHAR_CLOSE: begin
                        res[0] = csl_pkg::mk(csl_pkg::K_ERROR, csl_pkg::P_START, '0, '0,
                                             csl_pkg::E_OPEN_CHAR);
                        n_halt = 1'b1;
                    end
                    csl_pkg::M_OP1: begin
                        res[0].kind = lk[6:0];
                        cnt = 2'd1;
                    end
                    csl_pkg::M_OP2: begin
                        if (r_pend0 == 8'h2e) begin
                            res[0].kind = csl_pkg::K_MEMBER;
                            res[1].kind = csl_pkg::K_MEMBER;
                            res[1].pos  = csl_pkg::P_START_NEXT;
                            cnt = 2'd2;
                        end else begin
                            res[0].kind = (r_pend0 == 8'h3c) ? csl_pkg::K_SHL
                                                             : csl_pkg::K_SHR;
                            cnt = 2'd1;
                        end
                    end
                    default: cnt = 2'd0;
                endcase
                if (n_halt) begin
                    cnt = 2'd1;
                end else begin
                    res[cnt] = csl_pkg::mk(csl_pkg::K_EOF, csl_pkg::P_CUR, '0, '0,
                                           csl_pkg::E_NONE);
                    cnt = cnt + 2'd1;
                    n_mode = csl_pkg::M_DONE;
                end
            end else begin
                case (r_mode)
                    csl_pkg::M_IDENT: begin
                        if (csl_pkg::is_alpha(i_byte) || csl_pkg::is_digit(i_byte)) begin
                            if (r_ilen < 4'd8) begin
                                n_kwp = r_kwp | ({56'd0, i_byte} << {r_ilen[2:0], 3'b000});
                            end
                            if (r_ilen < 4'd15) begin
                                n_ilen = r_ilen + 4'd1;
                            end
                            res[0].kind = csl_pkg::K_TEXT;
                            res[0].chr  = i_byte;
                            cnt = 2'd1;
                        end else begin
                            res[0].kind = ident_kind;
                            cnt = 2'd1;
                            disp = 1'b1;
                        end
                    end
                    csl_pkg::M_NUMBER: begin
                        if (csl_pkg::is_digit(i_byte)) begin
                            n_num = (num_sum > {5'd0, csl_pkg::NUM_MAX}) ? csl_pkg::NUM_MAX
                                                                         : num_sum[30:0];
                        end else begin
                            res[0].kind = csl_pkg::K_NUMBER;
                            res[0].num  = r_num;
                            cnt = 2'd1;
                            disp = 1'b1;
                        end
                    end
                    csl_pkg::M_STRING: begin
                        if (i_byte == 8'h5c) begin
                            n_mode = csl_pkg::M_STR_ESC;
                        end else if (i_byte == 8'h22) begin
                            res[0].kind = csl_pkg::K_STRING;
                            cnt = 2'd1;
                            n_mode = csl_pkg::M_IDLE;
                        end else begin
                            res[0].kind = csl_pkg::K_TEXT;
                            res[0].chr  = i_byte;
                            cnt = 2'd1;
                        end
                    end
                    csl_pkg::M_STR_ESC: begin
                        cnt = 2'd1;
                        if (!esc[8]) begin
                            res[0] = csl_pkg::mk(csl_pkg::K_ERROR, csl_pkg::P_CUR, '0, '0,
                                                 csl_pkg::E_BAD_ESC);
                            n_halt = 1'b1;
                        end else begin
                            res[0].kind = csl_pkg::K_TEXT;
                            res[0].chr  = esc[7:0];
                            n_mode = csl_pkg::M_STRING;
                        end
                    end
                    csl_pkg::M_CHAR_BODY: begin
                        if (i_byte == 8'h5c) begin
                            n_mode = csl_pkg::M_CHAR_ESC;
                        end else begin
                            n_pend1 = i_byte;
                            n_mode = csl_pkg::M_CHAR_CLOSE;
                        end
                    end
                    csl_pkg::M_CHAR_ESC: begin
                        if (!esc[8]) begin
                            res[0] = csl_pkg::mk(csl_pkg::K_ERROR, csl_pkg::P_CUR, '0, '0,
                                                 csl_pkg::E_BAD_ESC);
                            cnt = 2'd1;
                            n_halt = 1'b1;
                        end else begin
                            n_pend1 = esc[7:0];
                            n_mode = csl_pkg::M_CHAR_CLOSE;
                        end
                    end
                    csl_pkg::M_CHAR_CLOSE: begin
                        cnt = 2'd1;
                        if (i_byte == 8'h27) begin
                            res[0].kind = csl_pkg::K_CHARLIT;
                            res[0].chr  = r_pend1;
                            n_mode = csl_pkg::M_IDLE;
                        end else begin
                            res[0] = csl_pkg::mk(csl_pkg::K_ERROR, csl_pkg::P_START, '0, '0,
                                                 csl_pkg::E_OPEN_CHAR);
                            n_halt = 1'b1;
                        end
                    end
                    csl_pkg::M_OP1: begin
                        if ((r_pend0 == 8'h2e || r_pend0 == 8'h3c || r_pend0 == 8'h3e)
                            && i_byte == r_pend0) begin
                            n_pend1 = i_byte;
                            n_mode = csl_pkg::M_OP2;
                        end else if (r_pend0 == 8'h2f && i_byte == 8'h2f) begin
                            n_mode = csl_pkg::M_COMMENT;
                        end else if (pk[7]) begin
                            res[0].kind = pk[6:0];
                            cnt = 2'd1;
                            n_mode = csl_pkg::M_IDLE;
                        end else begin
                            res[0].kind = lk[6:0];
                            cnt = 2'd1;
                            disp = 1'b1;
                        end
                    end
                    csl_pkg::M_OP2: begin
                        if (r_pend0 == 8'h2e) begin
                            if (i_byte == 8'h2e) begin
                                res[0].kind = csl_pkg::K_VARARG;
                                cnt = 2'd1;
                                n_mode = csl_pkg::M_IDLE;
                            end else begin
                                res[0].kind = csl_pkg::K_MEMBER;
                                res[1].kind = csl_pkg::K_MEMBER;
                                res[1].pos  = csl_pkg::P_START_NEXT;
                                cnt = 2'd2;
                                disp = 1'b1;
                            end
                        end else if (i_byte == 8'h3d) begin
                            res[0].kind = (r_pend0 == 8'h3c) ? csl_pkg::K_SHLEQ
                                                             : csl_pkg::K_SHREQ;
                            cnt = 2'd1;
                            n_mode = csl_pkg::M_IDLE;
                        end else begin
                            res[0].kind = (r_pend0 == 8'h3c) ? csl_pkg::K_SHL
                                                             : csl_pkg::K_SHR;
                            cnt = 2'd1;
                            disp = 1'b1;
                        end
                    end
                    csl_pkg::M_COMMENT: begin
                        if (i_byte == 8'h0a) begin
                            n_mode = csl_pkg::M_IDLE;
                        end
                    end
                    default: disp = 1'b1;
                endcase

                // Start a fresh token with the current byte.
                if (disp) begin
                    n_mode = csl_pkg::M_IDLE;
                    if (!csl_pkg::is_space(i_byte)) begin
                        n_sline = r_line;
                        n_scol  = r_col;
                        if (csl_pkg::is_digit(i_byte)) begin
                            n_num  = {23'd0, i_byte - 8'h30};
                            n_mode = csl_pkg::M_NUMBER;
                        end else if (csl_pkg::is_alpha(i_byte)) begin
                            n_kwp  = {56'd0, i_byte};
                            n_ilen = 4'd1;
                            n_mode = csl_pkg::M_IDENT;
                            res[cnt] = csl_pkg::mk(csl_pkg::K_TEXT, csl_pkg::P_CUR, '0,
                                                   i_byte, csl_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                        end else if (i_byte == 8'h22) begin
                            n_mode = csl_pkg::M_STRING;
                        end else if (i_byte == 8'h27) begin
                            n_mode = csl_pkg::M_CHAR_BODY;
                        end else if (sk[7]) begin
                            res[cnt] = csl_pkg::mk(sk[6:0], csl_pkg::P_CUR, '0, '0,
                                                   csl_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                        end else if (dk[7]) begin
                            n_pend0 = i_byte;
                            n_mode  = csl_pkg::M_OP1;
                        end else begin
                            res[cnt] = csl_pkg::mk(csl_pkg::K_ERROR, csl_pkg::P_CUR, '0,
                                                   '0, csl_pkg::E_UNEXPECTED);
                            cnt = cnt + 2'd1;
                            n_halt = 1'b1;
                        end
                    end
                end

                if (i_byte == 8'h0a) begin
                    if (r_line != LINE_MAX) begin
                        n_line = r_line + LINE_BITS'(1);
                    end
                    n_col = COLUMN_BITS'(1);
                end else if (r_col != COL_MAX) begin
                    n_col = r_col + COLUMN_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= csl_pkg::M_IDLE;
            r_pend0 <= '0;
            r_pend1 <= '0;
            r_num   <= '0;
            r_kwp   <= '0;
            r_ilen  <= '0;
            r_line  <= LINE_BITS'(1);
            r_col   <= COLUMN_BITS'(1);
            r_sline <= LINE_BITS'(1);
            r_scol  <= COLUMN_BITS'(1);
            r_halt  <= 1'b0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_pend0 <= n_pend0;
            r_pend1 <= n_pend1;
            r_num   <= n_num;
            r_kwp   <= n_kwp;
            r_ilen  <= n_ilen;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_halt  <= n_halt;
        end
    end

    // A result tagged P_CUR and emitted by dispatch uses the new start, which
    // equals the current position; errors at the current byte do too.
    assign o_burst.count = cnt;
    assign o_burst.r0    = res[0];
    assign o_burst.r1    = res[1];
    assign o_burst.r2    = res[2];
    assign o_start_line  = r_sline;
    assign o_start_col   = r_scol;
    assign o_cur_line    = r_line;
    assign o_cur_col     = r_col;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt flag cleared without reset");
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> cnt == 2'd0) else $error("results while halted");
    a_col_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col != '0 && r_line != '0) else $error("position fell to zero");
`endif

endmodule

// File: rtl/core/csl_back.sv
// Back part: holds a queue of resolved results, one per entry, and serves
// them oldest first.
module csl_back #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12,
    parameter int DEPTH_LOG2  = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  csl_pkg::t_burst        i_burst,
    input  logic [LINE_BITS-1:0]   i_start_line,
    input  logic [COLUMN_BITS-1:0] i_start_col,
    input  logic [LINE_BITS-1:0]   i_cur_line,
    input  logic [COLUMN_BITS-1:0] i_cur_col,
    output logic                   o_room,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [6:0]             o_kind,
    output logic [LINE_BITS-1:0]   o_line,
    output logic [COLUMN_BITS-1:0] o_col,
    output logic [30:0]            o_num,
    output logic [7:0]             o_chr,
    output logic [2:0]             o_err,
    output logic                   o_last
);

    localparam int DEPTH = 1 << DEPTH_LOG2;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

    typedef struct packed {
        logic [6:0]             kind;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic [30:0]            num;
        logic [7:0]             chr;
        logic [2:0]             err;
        logic                   last;
    } t_entry;

    t_entry                r_q [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wp, r_rp;
    logic [DEPTH_LOG2:0]   r_cnt, n_cnt;
    t_entry                ent [3];
    csl_pkg::t_res         src [3];
    logic                  do_pop;

    assign src[0] = i_burst.r0;
    assign src[1] = i_burst.r1;
    assign src[2] = i_burst.r2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ent[i].kind = src[i].kind;
            ent[i].num  = src[i].num;
            ent[i].chr  = src[i].chr;
            ent[i].err  = src[i].err;
            ent[i].last = (2'(i) == i_burst.count - 2'd1);
            case (src[i].pos)
                csl_pkg::P_CUR: begin
                    ent[i].line = i_cur_line;
                    ent[i].col  = i_cur_col;
                end
                csl_pkg::P_START_NEXT: begin
                    ent[i].line = i_start_line;
                    ent[i].col  = (i_start_col != COL_MAX) ? i_start_col + COLUMN_BITS'(1)
                                                           : COL_MAX;
                end
                default: begin
                    ent[i].line = i_start_line;
                    ent[i].col  = i_start_col;
                end
            endcase
        end
    end

    assign o_empty = (r_cnt == '0);
    assign do_pop  = i_pop && !o_empty;
    // Keep space for a whole burst of three.
    assign o_room  = (r_cnt <= (DEPTH_LOG2+1)'(DEPTH - 3));

    always_comb begin
        n_cnt = r_cnt - (DEPTH_LOG2+1)'(do_pop);
        if (i_push) begin
            n_cnt = n_cnt + (DEPTH_LOG2+1)'(i_burst.count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < i_burst.count) begin
                    r_q[r_wp + DEPTH_LOG2'(i)] <= ent[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + DEPTH_LOG2'(i_burst.count);
            end
            if (do_pop) begin
                r_rp <= r_rp + DEPTH_LOG2'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    t_entry head;
    assign head   = r_q[r_rp];
    assign o_kind = head.kind;
    assign o_line = head.line;
    assign o_col  = head.col;
    assign o_num  = head.num;
    assign o_chr  = head.chr;
    assign o_err  = head.err;
    assign o_last = head.last;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (DEPTH_LOG2+1)'(DEPTH)) else $error("result queue overflow");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room) else $error("push without room");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push && !do_pop) |=> $stable(r_cnt)) else $error("count moved while idle");
`endif

endmodule

// File: rtl/core/c_source_lexer_core.sv
// Streaming C lexer core.
// Input channel: drive i_byte_in / i_end_of_input with push; a request is
//   taken at a rising edge with push high and full low. One byte per cycle
//   is sustained while full stays low.
// Result channel: while empty is low the oldest result stands on the o_
//   ports; raise pop to take it. Each request gives zero to three results;
//   o_last_of_run marks the last one of a request.
// Timing: the front part classifies a byte in the cycle it is taken; its
//   results are written into the result queue by the edge that takes it.
// Throughput: one request per cycle while the queue holds at least three free
//   entries; a request that yields three results needs three pops to drain,
//   so a slow receiver throttles input through full.
// Reset: i_rst_n low at a clock edge clears lexing mode, position (line 1,
//   column 1), halt flag and the queue. No clearing pass is needed.
// Errors: an error result is queued and the lexer then drops every later
//   request silently until reset.
// After end of input, every further request yields one more EOF token, unless the lexer has halted on an error.
module c_source_lexer_core #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             i_byte_in,
    input  logic                   i_end_of_input,
    output logic                   empty,
    input  logic                   pop,
    output logic [6:0]             o_token_kind,
    output logic [LINE_BITS-1:0]   o_start_line,
    output logic [COLUMN_BITS-1:0] o_start_column,
    output logic [30:0]            o_number_value,
    output logic [7:0]             o_char_value,
    output logic [2:0]             o_error_code,
    output logic                   o_last_of_run
);

    csl_pkg::t_burst        burst;
    logic [LINE_BITS-1:0]   sline, cline;
    logic [COLUMN_BITS-1:0] scol, ccol;
    logic                   room, take;

    // Accept only when the queue can hold a whole burst.
    assign full = !room;
    assign take = push && room;

    csl_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_byte       (i_byte_in),
        .i_eoi        (i_end_of_input),
        .o_burst      (burst),
        .o_start_line (sline),
        .o_start_col  (scol),
        .o_cur_line   (cline),
        .o_cur_col    (ccol)
    );

    // Results go straight into the queue in the accepting cycle; positions
    // are resolved against the state seen before the byte.
    csl_back #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .DEPTH_LOG2  (3)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (take),
        .i_burst      (burst),
        .i_start_line (sline),
        .i_start_col  (scol),
        .i_cur_line   (cline),
        .i_cur_col    (ccol),
        .o_room       (room),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_kind       (o_token_kind),
        .o_line       (o_start_line),
        .o_col        (o_start_column),
        .o_num        (o_number_value),
        .o_chr        (o_char_value),
        .o_err        (o_error_code),
        .o_last       (o_last_of_run)
    );

`ifndef SYNTHESIS
    a_take_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !take) else $error("request taken while full");
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind == csl_pkg::K_ERROR) |-> o_last_of_run)
        else $error("error result not last of its run");
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind != csl_pkg::K_ERROR) |-> o_error_code == csl_pkg::E_NONE)
        else $error("error code on a plain result");
`endif

endmodule

// File: test/c_source_lexer_core_tb.sv
`timescale 1ns / 100ps

module c_source_lexer_core_tb;

    // Idle limit of the watchdog below: the run is stopped when nothing moves on either side.
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [6:0]  kind;
        logic [15:0] line;
        logic [11:0] col;
        logic [30:0] num;
        logic [7:0]  chr;
        logic [2:0]  err;
        logic        last;
    } t_tok;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } t_req;

    // Directed row: one source byte, with its result typed in where it is obvious.
    typedef struct {
        logic [7:0]  ch;
        logic        eoi;
        bit          known;
        logic [6:0]  kind;
        logic [15:0] line;
        logic [11:0] col;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  byte_in;
    logic        eoi_in;
    logic        empty;
    logic        pop;
    logic [6:0]  o_token_kind;
    logic [15:0] o_start_line;
    logic [11:0] o_start_column;
    logic [30:0] o_number_value;
    logic [7:0]  o_char_value;
    logic [2:0]  o_error_code;
    logic        o_last_of_run;

    c_source_lexer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_byte_in      (byte_in),
        .i_end_of_input (eoi_in),
        .empty          (empty),
        .pop            (pop),
        .o_token_kind   (o_token_kind),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_number_value (o_number_value),
        .o_char_value   (o_char_value),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Lexer state as the testbench sees it.
    csl_pkg::t_mode lx_mode;
    logic [7:0]  lx_op_char;
    logic [7:0]  lx_held_char;
    logic [30:0] lx_accum;
    logic [63:0] lx_prefix;
    logic [3:0]  lx_len;
    logic [15:0] lx_line;
    logic [11:0] lx_col;
    logic [15:0] tok_line;
    logic [11:0] tok_col;
    bit          lx_halted;

    t_tok step_q[$];     // results of the request being predicted
    t_tok tokens_due[$]; // results still owed by the block
    t_req source_q[$];
    int   errors;
    bit   quiet;
    int   stall_cycles = 0;

    string op_list[] = '{"(", ")", ";", "{", "}", ",", "[", "]", "~", ":",
                         "...", ".", "..", "+=", "++", "+", "-=", "--", "->", "-",
                         "*=", "*", "/=", "/", "%=", "%", "&=", "&&", "&", "|=",
                         "||", "|", "^=", "^", "<=", "<<=", "<<", "<", ">=", ">>=",
                         ">>", ">", "==", "=", "!=", "!"};

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic bit is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    // K_ERROR doubles as "no such operator" in the three lookups below.
    function automatic logic [6:0] single_of(input logic [7:0] b);
        case (b)
            "(":     return csl_pkg::K_PAREN_O;
            ")":     return csl_pkg::K_PAREN_C;
            ";":     return csl_pkg::K_SEMI;
            "{":     return csl_pkg::K_BRACE_O;
            "}":     return csl_pkg::K_BRACE_C;
            ",":     return csl_pkg::K_COMMA;
            "[":     return csl_pkg::K_BRACK_O;
            "]":     return csl_pkg::K_BRACK_C;
            "~":     return csl_pkg::K_TILDE;
            ":":     return csl_pkg::K_COLON;
            default: return csl_pkg::K_ERROR;
        endcase
    endfunction

    function automatic logic [6:0] lead_of(input logic [7:0] b);
        case (b)
            ".":     return csl_pkg::K_MEMBER;
            "+":     return csl_pkg::K_ADD;
            "-":     return csl_pkg::K_SUB;
            "*":     return csl_pkg::K_MUL;
            "/":     return csl_pkg::K_DIV;
            "%":     return csl_pkg::K_REM;
            "&":     return csl_pkg::K_AND;
            "|":     return csl_pkg::K_OR;
            "^":     return csl_pkg::K_XOR;
            "<":     return csl_pkg::K_LT;
            ">":     return csl_pkg::K_GT;
            "=":     return csl_pkg::K_ASSIGN;
            "!":     return csl_pkg::K_BANG;
            default: return csl_pkg::K_ERROR;
        endcase
    endfunction

    function automatic logic [6:0] pair_of(input logic [7:0] c, input logic [7:0] b);
        if (b == "=") begin
            case (c)
                "+":     return csl_pkg::K_ADDEQ;
                "-":     return csl_pkg::K_SUBEQ;
                "*":     return csl_pkg::K_MULEQ;
                "/":     return csl_pkg::K_DIVEQ;
                "%":     return csl_pkg::K_REMEQ;
                "&":     return csl_pkg::K_ANDEQ;
                "|":     return csl_pkg::K_OREQ;
                "^":     return csl_pkg::K_XOREQ;
                "<":     return csl_pkg::K_LE;
                ">":     return csl_pkg::K_GE;
                "=":     return csl_pkg::K_EQ;
                "!":     return csl_pkg::K_NE;
                default: return csl_pkg::K_ERROR;
            endcase
        end
        if (c == "+" && b == "+") return csl_pkg::K_INC;
        if (c == "-" && b == "-") return csl_pkg::K_DEC;
        if (c == "-" && b == ">") return csl_pkg::K_ARROW;
        if (c == "&" && b == "&") return csl_pkg::K_LOGAND;
        if (c == "|" && b == "|") return csl_pkg::K_LOGOR;
        return csl_pkg::K_ERROR;
    endfunction

    // {accepted, decoded byte}
    function automatic logic [8:0] unescape(input logic [7:0] b);
        case (b)
            "n":     return {1'b1, 8'd10};
            "\\":    return {1'b1, b};
            "'":     return {1'b1, b};
            "\"":    return {1'b1, b};
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic [6:0] word_kind();
        for (int i = 0; i < 18; i++)
            if (lx_len == csl_pkg::KW_LEN[i] && lx_prefix == csl_pkg::KW_TEXT[i])
                return csl_pkg::K_KW_BASE + 7'(i);
        return csl_pkg::K_IDENT;
    endfunction

    task automatic note(input logic [6:0] k, input logic [15:0] l, input logic [11:0] c,
                        input logic [30:0] n, input logic [7:0] ch, input logic [2:0] e);
        t_tok t;
        t = '{k, l, c, n, ch, e, 1'b0};
        if (step_q.size() < 3) step_q.push_back(t);
    endtask

    task automatic note_tok(input logic [6:0] k, input logic [30:0] n, input logic [7:0] ch);
        note(k, tok_line, tok_col, n, ch, csl_pkg::E_NONE);
    endtask

    task automatic halt_with(input logic [2:0] e, input logic [15:0] l, input logic [11:0] c);
        note(csl_pkg::K_ERROR, l, c, 0, 0, e);
        lx_halted = 1'b1;
    endtask

    task automatic two_dots();
        note_tok(csl_pkg::K_MEMBER, 0, 0);
        note(csl_pkg::K_MEMBER, tok_line, (tok_col == 12'hFFF) ? tok_col : tok_col + 12'd1,
             0, 0, csl_pkg::E_NONE);
    endtask

    // A byte seen between tokens: drop whitespace, open a token or fail.
    task automatic open_token(input logic [7:0] b, input logic [15:0] l, input logic [11:0] c);
        lx_mode = csl_pkg::M_IDLE;
        if (b == " " || (b >= 8'd9 && b <= 8'd13)) return;
        tok_line = l;
        tok_col  = c;
        if (is_num(b)) begin
            lx_accum = 31'(b - "0");
            lx_mode  = csl_pkg::M_NUMBER;
        end else if (is_letter(b)) begin
            lx_prefix = 64'(b);
            lx_len    = 4'd1;
            lx_mode   = csl_pkg::M_IDENT;
            note_tok(csl_pkg::K_TEXT, 0, b);
        end else if (b == "\"") begin
            lx_mode = csl_pkg::M_STRING;
        end else if (b == "'") begin
            lx_mode = csl_pkg::M_CHAR_BODY;
        end else if (single_of(b) != csl_pkg::K_ERROR) begin
            note_tok(single_of(b), 0, 0);
        end else if (lead_of(b) != csl_pkg::K_ERROR) begin
            lx_op_char = b;
            lx_mode    = csl_pkg::M_OP1;
        end else begin
            halt_with(csl_pkg::E_UNEXPECTED, l, c);
        end
    endtask

    task automatic lex_byte(input logic [7:0] b, input logic [15:0] l, input logic [11:0] c);
        logic [63:0] wide;
        logic [8:0]  esc;
        case (lx_mode)
            csl_pkg::M_IDENT: begin
                if (is_letter(b) || is_num(b)) begin
                    if (lx_len < 4'd8) lx_prefix |= 64'(b) << (8 * lx_len);
                    if (lx_len < 4'd15) lx_len++;
                    note_tok(csl_pkg::K_TEXT, 0, b);
                end else begin
                    note_tok(word_kind(), 0, 0);
                    open_token(b, l, c);
                end
            end
            csl_pkg::M_NUMBER: begin
                if (is_num(b)) begin
                    wide = 64'(lx_accum) * 10 + 64'(b - "0");
                    lx_accum = (wide > 64'(csl_pkg::NUM_MAX)) ? csl_pkg::NUM_MAX : wide[30:0];
                end else begin
                    note_tok(csl_pkg::K_NUMBER, lx_accum, 0);
                    open_token(b, l, c);
                end
            end
            csl_pkg::M_STRING: begin
                if (b == "\\") begin
                    lx_mode = csl_pkg::M_STR_ESC;
                end else if (b == "\"") begin
                    note_tok(csl_pkg::K_STRING, 0, 0);
                    lx_mode = csl_pkg::M_IDLE;
                end else begin
                    note_tok(csl_pkg::K_TEXT, 0, b);
                end
            end
            csl_pkg::M_STR_ESC: begin
                esc = unescape(b);
                if (!esc[8]) halt_with(csl_pkg::E_BAD_ESC, l, c);
                else begin
                    note_tok(csl_pkg::K_TEXT, 0, esc[7:0]);
                    lx_mode = csl_pkg::M_STRING;
                end
            end
            csl_pkg::M_CHAR_BODY: begin
                if (b == "\\") lx_mode = csl_pkg::M_CHAR_ESC;
                else begin
                    lx_held_char = b;
                    lx_mode      = csl_pkg::M_CHAR_CLOSE;
                end
            end
            csl_pkg::M_CHAR_ESC: begin
                esc = unescape(b);
                if (!esc[8]) halt_with(csl_pkg::E_BAD_ESC, l, c);
                else begin
                    lx_held_char = esc[7:0];
                    lx_mode      = csl_pkg::M_CHAR_CLOSE;
                end
            end
            csl_pkg::M_CHAR_CLOSE: begin
                if (b == "'") begin
                    note_tok(csl_pkg::K_CHARLIT, 0, lx_held_char);
                    lx_mode = csl_pkg::M_IDLE;
                end else begin
                    halt_with(csl_pkg::E_OPEN_CHAR, tok_line, tok_col);
                end
            end
            csl_pkg::M_OP1: begin
                if ((lx_op_char == "." || lx_op_char == "<" || lx_op_char == ">")
                        && b == lx_op_char) begin
                    lx_mode = csl_pkg::M_OP2;
                end else if (lx_op_char == "/" && b == "/") begin
                    lx_mode = csl_pkg::M_COMMENT;
                end else if (pair_of(lx_op_char, b) != csl_pkg::K_ERROR) begin
                    note_tok(pair_of(lx_op_char, b), 0, 0);
                    lx_mode = csl_pkg::M_IDLE;
                end else begin
                    note_tok(lead_of(lx_op_char), 0, 0);
                    open_token(b, l, c);
                end
            end
            csl_pkg::M_OP2: begin
                if (lx_op_char == ".") begin
                    if (b == ".") begin
                        note_tok(csl_pkg::K_VARARG, 0, 0);
                        lx_mode = csl_pkg::M_IDLE;
                    end else begin
                        two_dots();
                        open_token(b, l, c);
                    end
                end else if (b == "=") begin
                    note_tok((lx_op_char == "<") ? csl_pkg::K_SHLEQ : csl_pkg::K_SHREQ, 0, 0);
                    lx_mode = csl_pkg::M_IDLE;
                end else begin
                    note_tok((lx_op_char == "<") ? csl_pkg::K_SHL : csl_pkg::K_SHR, 0, 0);
                    open_token(b, l, c);
                end
            end
            csl_pkg::M_COMMENT: begin
                if (b == 8'd10) lx_mode = csl_pkg::M_IDLE;
            end
            default: open_token(b, l, c);
        endcase
    endtask

    task automatic lex_end(input logic [15:0] l, input logic [11:0] c);
        case (lx_mode)
            csl_pkg::M_IDENT:  note_tok(word_kind(), 0, 0);
            csl_pkg::M_NUMBER: note_tok(csl_pkg::K_NUMBER, lx_accum, 0);
            csl_pkg::M_STRING: begin
                halt_with(csl_pkg::E_OPEN_STR, tok_line, tok_col);
                return;
            end
            csl_pkg::M_STR_ESC, csl_pkg::M_CHAR_ESC: begin
                halt_with(csl_pkg::E_BAD_ESC, l, c);
                return;
            end
            csl_pkg::M_CHAR_BODY, csl_pkg::M_CHAR_CLOSE: begin
                halt_with(csl_pkg::E_OPEN_CHAR, tok_line, tok_col);
                return;
            end
            csl_pkg::M_OP1: note_tok(lead_of(lx_op_char), 0, 0);
            csl_pkg::M_OP2: begin
                if (lx_op_char == ".") two_dots();
                else note_tok((lx_op_char == "<") ? csl_pkg::K_SHL : csl_pkg::K_SHR, 0, 0);
            end
            default: ;
        endcase
        note(csl_pkg::K_EOF, l, c, 0, 0, csl_pkg::E_NONE);
        lx_mode = csl_pkg::M_DONE;
    endtask

    // Work out the results of one request into step_q and advance the state.
    task automatic lex_step(input logic [7:0] b, input logic eoi);
        logic [15:0] l;
        logic [11:0] c;
        l = lx_line;
        c = lx_col;
        step_q.delete();
        if (lx_halted) return;
        if (lx_mode == csl_pkg::M_DONE) begin
            note(csl_pkg::K_EOF, l, c, 0, 0, csl_pkg::E_NONE);
        end else if (eoi) begin
            lex_end(l, c);
        end else begin
            lex_byte(b, l, c);
            if (b == 8'd10) begin
                if (lx_line != 16'hFFFF) lx_line++;
                lx_col = 12'd1;
            end else if (lx_col != 12'hFFF) begin
                lx_col++;
            end
        end
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------- source text

    task automatic put(input logic [7:0] b);
        t_req r;
        r = '{b, 1'b0};
        source_q.push_back(r);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic put_end();
        t_req r;
        r = '{8'($urandom_range(255)), 1'b1};
        source_q.push_back(r);
    endtask

    function automatic logic [7:0] any_letter();
        int r;
        r = $urandom_range(52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] any_space();
        int r;
        r = $urandom_range(5);
        return (r == 0) ? 8'h20 : 8'(8 + r);
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(3))
            0:       return "n";
            1:       return "\\";
            2:       return "'";
            default: return "\"";
        endcase
    endfunction

    // One well-formed token (or comment) with random content; returns its class.
    // 0 word, 1 number, 2 string, 3 char, 4 operator, 5 comment
    task automatic put_token(output int cls);
        int         n;
        logic [7:0] b;
        cls = $urandom_range(5);
        case (cls)
            0: begin
                if ($urandom_range(1)) begin
                    n = $urandom_range(17);
                    for (int i = 0; i < csl_pkg::KW_LEN[n]; i++)
                        put(csl_pkg::KW_TEXT[n][8 * i +: 8]);
                end else begin
                    n = ($urandom_range(5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
                    put(any_letter());
                    for (int i = 1; i < n; i++)
                        put($urandom_range(3) == 0 ? 8'("0" + $urandom_range(9))
                                                   : any_letter());
                end
            end
            1: begin
                n = ($urandom_range(4) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 3);
                for (int i = 0; i < n; i++) put(8'("0" + $urandom_range(9)));
            end
            2: begin
                put("\"");
                n = $urandom_range(6);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(6) == 0) begin
                        put("\\");
                        put(escape_letter());
                    end else begin
                        do b = 8'($urandom_range(255)); while (b == "\"" || b == "\\");
                        put(b);
                    end
                end
                put("\"");
            end
            3: begin
                put("'");
                if ($urandom_range(3) == 0) begin
                    put("\\");
                    put(escape_letter());
                end else begin
                    do b = 8'($urandom_range(255)); while (b == "\\");
                    put(b);
                end
                put("'");
            end
            4: put_text(op_list[$urandom_range(op_list.size() - 1)]);
            default: begin
                put_text("//");
                n = $urandom_range(8);
                for (int i = 0; i < n; i++) begin
                    do b = 8'($urandom_range(255)); while (b == 8'd10);
                    put(b);
                end
                put(8'd10);
            end
        endcase
    endtask

    // Close the stream in one of the ways a source can end, good or broken.
    task automatic put_ending();
        put(" ");
        case ($urandom_range(12))
            0:  ;
            1:  put_text("ab");
            2:  put_text("123");
            3:  put_text("\"ab");
            4:  put_text("\"a\\");
            5:  put_text("'");
            6:  put_text("'a");
            7:  put_text("\"\\q");
            8:  put_text("'ab");
            9:  put($urandom_range(1) ? 8'($urandom_range(128, 255)) : "@");
            10: put_text("// x");
            11: put_text("..");
            default: put_text("<<");
        endcase
        put_end();
        // further requests: more EOF tokens, or nothing once halted
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(1)) put_end();
            else put(8'($urandom_range(255)));
        end
    endtask

    // ---------------------------------------------------------------- driving

    task automatic send_req(input t_req r, input bit known, input logic [6:0] k,
                            input logic [15:0] l, input logic [11:0] c);
        t_tok t;
        while (!quiet && $urandom_range(99) < 36) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        byte_in <= r.ch;
        eoi_in  <= r.eoi;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        lex_step(r.ch, r.eoi);
        if (known) begin
            t = '{k, l, c, 0, 0, csl_pkg::E_NONE, 1'b1};
            tokens_due.push_back(t);
        end else begin
            foreach (step_q[i]) tokens_due.push_back(step_q[i]);
        end
    endtask

    // Directed opening: the first two rows have results plain at a glance.
    t_row opening[] = '{
        '{"(",    1'b0, 1'b1, csl_pkg::K_PAREN_O, 16'd1, 12'd1},
        '{")",    1'b0, 1'b1, csl_pkg::K_PAREN_C, 16'd1, 12'd2},
        '{8'd10,  1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{"i",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{"f",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{" ",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{"'",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{"\\",   1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{"n",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{"'",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{"\"",   1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{8'hFF,  1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{"\"",   1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{">",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{">",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{"=",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{".",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{".",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{".",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{"/",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{"/",    1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{8'h80,  1'b0, 1'b0, csl_pkg::K_EOF, 0, 0},
        '{8'd10,  1'b0, 1'b0, csl_pkg::K_EOF, 0, 0}
    };

    initial begin
        int   cls;
        int   prev_cls;
        t_req r;

        i_rst_n  = 1'b0;
        push     = 1'b0;
        byte_in  = 8'd0;
        eoi_in   = 1'b0;
        errors   = 0;
        quiet    = 1'b0;

        lx_mode      = csl_pkg::M_IDLE;
        lx_op_char   = 8'd0;
        lx_held_char = 8'd0;
        lx_accum     = 31'd0;
        lx_prefix    = 64'd0;
        lx_len       = 4'd0;
        lx_line      = 16'd1;
        lx_col       = 12'd1;
        tok_line     = 16'd1;
        tok_col      = 12'd1;
        lx_halted    = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[i]) begin
            r = '{opening[i].ch, opening[i].eoi};
            send_req(r, opening[i].known, opening[i].kind, opening[i].line, opening[i].col);
        end

        // Random text: tokens kept apart by whitespace, except that a finished
        // token may run straight into the next one unless it was an operator or a comment.
        prev_cls = 4;
        while (source_q.size() < 170) begin
            if (prev_cls == 4 || prev_cls == 5 || $urandom_range(9) < 6) put(any_space());
            put_token(cls);
            prev_cls = cls;
        end
        put_ending();

        for (int i = 0; i < source_q.size(); i++) begin
            quiet = (i >= 80 && i < 140);
            send_req(source_q[i], 1'b0, csl_pkg::K_EOF, 0, 0);
        end
        quiet = 1'b0;
        push <= 1'b0;

        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0 && tokens_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ---------------------------------------------------------------- result side

    always @(posedge i_clk) begin
        t_tok w;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (tokens_due.size() == 0) begin
                    flag_mismatch("unexpected result, kind", o_token_kind, -1);
                end else begin
                    w = tokens_due.pop_front();
                    if (o_token_kind !== w.kind) flag_mismatch("kind", o_token_kind, w.kind);
                    if (o_start_line !== w.line) flag_mismatch("line", o_start_line, w.line);
                    if (o_start_column !== w.col) flag_mismatch("column", o_start_column, w.col);
                    if (o_number_value !== w.num) flag_mismatch("number", o_number_value, w.num);
                    if (o_char_value !== w.chr) flag_mismatch("char", o_char_value, w.chr);
                    if (o_error_code !== w.err) flag_mismatch("error", o_error_code, w.err);
                    if (o_last_of_run !== w.last) flag_mismatch("last", o_last_of_run, w.last);
                end
            end
            pop <= quiet || ($urandom_range(99) >= 36);
        end
    end

    // Drop the run if no request moves on either side for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/core/csl_pkg.sv
rtl/core/csl_front.sv
rtl/core/csl_back.sv
rtl/core/c_source_lexer_core.sv
test/c_source_lexer_core_tb.sv
